>>> rtl/core/dtpc_pkg.sv
`timescale 1ns / 1ps

package dtpc_pkg;

  // Depth in Q20.12 millimetres, offset span and reciprocal
  localparam int unsigned DEPTH_W = 32;
  localparam int unsigned OFFS_W  = 25;
  localparam int unsigned RECIP_W = 23;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned PROD_W  = OFFS_W + RECIP_W;

  localparam logic [15:0]        SCALE_ONE = 16'd4096;
  localparam logic [DEPTH_W-1:0] NEAR_Q12  = 32'd1024000;
  localparam logic [DEPTH_W-1:0] FAR_Q12   = 32'd20480000;
  localparam logic [RECIP_W-1:0] RECIP_Q32 = 23'd7233629;
  localparam logic [FRAC_W-1:0]  N_ONE     = 16'd32768;
  localparam logic [FRAC_W-1:0]  N_HALF    = 16'd16384;

  typedef struct packed {
    logic               zero;
    logic [DEPTH_W-1:0] depth;
  } depth_t;

  typedef struct packed {
    logic              zero;
    logic              near;
    logic              far;
    logic [OFFS_W-1:0] offs;
  } range_t;

  typedef struct packed {
    logic              zero;
    logic              near;
    logic              far;
    logic [FRAC_W-1:0] quot;
  } frac_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

endpackage

>>> rtl/core/depth_to_pseudo_color.sv
`timescale 1ns / 1ps

// Depth to pseudo-color preview.
// Input stream: one raw 16-bit depth sample per item on in_tdata; zero
// means no measurement and comes out black.
// Output stream: one RGB pixel per item on out_tdata, red in the low byte,
// then green, then blue. Near depths are red, far depths blue, green is
// bright at both ends of the 250 mm to 5000 mm ramp.
// Config: cfg_data sets the scale (mm per raw unit, unsigned Q4.12, zero
// reads as 1.0). cfg_ready is always high; write only while the stream is
// drained.
// Pipeline: one register per stage, in order: scale multiply, range compare,
// reciprocal multiply, color map.
// Throughput: one item per cycle; every stage holds its item and its valid
// bit when the next one is full, so a receiver stall backs up through
// in_tready without losing or repeating items.
// Reset (rst_n low, synchronous): the pipeline empties and the scale
// returns to 1.0.
module depth_to_pseudo_color
  import dtpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] depth_raw
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] scale_r;
  logic        a_valid;
  logic        a_ready;
  depth_t      a_data;
  logic        b_valid;
  logic        b_ready;
  range_t      b_data;
  logic        c_valid;
  logic        c_ready;
  frac_t       c_data;
  pixel_t      pix;

  // Scale register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_ONE;
    end else if (cfg_valid) begin
      scale_r <= cfg_data;
    end
  end

  dtpc_depth u_depth (
    .clk       (clk),
    .rst_n     (rst_n),
    .scale     (scale_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .raw       (in_tdata),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .out_data  (a_data)
  );

  dtpc_range u_range (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_data   (a_data),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  dtpc_recip u_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_data   (b_data),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_data  (c_data)
  );

  dtpc_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .in_data   (c_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (pix)
  );

  assign out_tdata = pix;

endmodule

>>> rtl/core/dtpc_depth.sv
`timescale 1ns / 1ps

module dtpc_depth
  import dtpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] scale,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] raw,
  output logic        out_valid,
  input  logic        out_ready,
  output depth_t      out_data
);

  logic        valid_r;
  depth_t      data_r;
  depth_t      data_nxt;
  logic [15:0] scale_eff;
  logic        load;

  assign load     = !valid_r || out_ready;
  assign in_ready = load;

  // Treat a zero scale as 1.0, then scale the raw sample
  always_comb begin
    scale_eff      = (scale == 16'd0) ? SCALE_ONE : scale;
    data_nxt.zero  = (raw == 16'd0);
    data_nxt.depth = {16'd0, raw} * {16'd0, scale_eff};
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> rtl/core/dtpc_range.sv
`timescale 1ns / 1ps

module dtpc_range
  import dtpc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  depth_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output range_t out_data
);

  logic               valid_r;
  range_t             data_r;
  range_t             data_nxt;
  logic [DEPTH_W-1:0] diff;
  logic               load;

  assign load     = !valid_r || out_ready;
  assign in_ready = load;

  // Classify against the near and far limits, form the offset from near
  always_comb begin
    diff          = in_data.depth - NEAR_Q12;
    data_nxt.zero = in_data.zero;
    data_nxt.near = (in_data.depth <= NEAR_Q12);
    data_nxt.far  = (in_data.depth >= FAR_Q12);
    data_nxt.offs = diff[OFFS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> rtl/core/dtpc_recip.sv
`timescale 1ns / 1ps

module dtpc_recip
  import dtpc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  range_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output frac_t  out_data
);

  logic              valid_r;
  frac_t             data_r;
  frac_t             data_nxt;
  logic [PROD_W-1:0] prod;
  logic              load;

  assign load     = !valid_r || out_ready;
  assign in_ready = load;

  // Divide by the span through a scaled reciprocal, keep product bits 32 and up as a Q1.15 fraction
  always_comb begin
    prod          = {{RECIP_W{1'b0}}, in_data.offs} * {{OFFS_W{1'b0}}, RECIP_Q32};
    data_nxt.zero = in_data.zero;
    data_nxt.near = in_data.near;
    data_nxt.far  = in_data.far;
    data_nxt.quot = prod[PROD_W-1:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> rtl/core/dtpc_color.sv
`timescale 1ns / 1ps

module dtpc_color
  import dtpc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  frac_t  in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output pixel_t out_data
);

  logic              valid_r;
  pixel_t            data_r;
  pixel_t            data_nxt;
  logic [FRAC_W-1:0] frac;
  logic [FRAC_W-1:0] mid_off;
  logic [FRAC_W-1:0] inv;
  logic [23:0]       red_p;
  logic [23:0]       green_p;
  logic [23:0]       blue_p;
  logic              load;

  assign load     = !valid_r || out_ready;
  assign in_ready = load;

  // Clamp the fraction, then map it onto the three ramps; zero samples map to black
  always_comb begin
    if (in_data.near) begin
      frac = '0;
    end else if (in_data.far || (in_data.quot > N_ONE)) begin
      frac = N_ONE;
    end else begin
      frac = in_data.quot;
    end
    mid_off = (frac > N_HALF) ? (frac - N_HALF) : (N_HALF - frac);
    inv     = N_ONE - frac;
    red_p   = ({8'd0, inv} << 8) - {8'd0, inv};
    green_p = ({8'd0, mid_off} << 9) - ({8'd0, mid_off} << 1);
    blue_p  = ({8'd0, frac} << 8) - {8'd0, frac};
    if (in_data.zero) begin
      data_nxt = '0;
    end else begin
      data_nxt.red   = red_p[22:15];
      data_nxt.green = green_p[22:15];
      data_nxt.blue  = blue_p[22:15];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
